@@ rtl/core/tkst_pkg.sv @@
package tkst_pkg;

  localparam int KEY_SLOTS_DEF     = 8;
  localparam int VALUE_ENTRIES_DEF = 64;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 8;
  localparam int TID_W  = 31;
  localparam int DATA_W = 64;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

@@ rtl/core/thread_keyed_storage_table.sv @@
// Thread-keyed storage table.
// Input channel (in_valid / in_stall) carries one operation per beat: create a key,
// delete a key, get or set the value a thread keeps under a key. Output channel
// (out_valid / out_stall) returns one result beat per operation, in order: status,
// new_key (on create) and read_value (on get).
// Value entries live in a single-port-write, registered-read memory that every
// delete, get and set walks one entry per cycle. A set adds a write-back step after
// the walk. Create walks the key-slot flags instead; an operation rejected for a bad
// or inactive key or a zero thread id goes straight to its result.
// One operation is in flight at a time; the next beat is taken as soon as the
// result has moved into the output register, even if the receiver has not yet
// taken it.
// After reset the block sweeps the value memory to zero, one entry per cycle,
// holding in_stall high; key slots clear at once.
// When the receiver stalls, the output beat holds; a following result waits in
// the block until the output register frees, and in_stall stays high meanwhile.
module thread_keyed_storage_table
  import tkst_pkg::*;
#(
  parameter int KEY_SLOTS     = KEY_SLOTS_DEF,
  parameter int VALUE_ENTRIES = VALUE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   opcode,
  input  logic [KEY_W-1:0]  key_number,
  input  logic [TID_W-1:0]  thread_id,
  input  logic [DATA_W-1:0] item_value,
  input  logic [DATA_W-1:0] cleanup_handle,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   status,
  output logic [KEY_W-1:0]  new_key,
  output logic [DATA_W-1:0] read_value
);

  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int IDX_W  = (VALUE_ENTRIES > 1) ? $clog2(VALUE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(VALUE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  state_t state;

  // Storage: entry memory and the destructor handle per key slot.
  entry_t            entry_mem [VALUE_ENTRIES];
  logic [DATA_W-1:0] slot_cleanup [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] slot_active;

  // Latched operation.
  opcode_t           op_r;
  logic [KEY_W-1:0]  key_r;
  logic [TID_W-1:0]  tid_r;
  logic [DATA_W-1:0] val_r;

  // Walk counters and the registered read path.
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] slot_cnt;
  entry_t            rd_data;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;

  // Scan findings.
  logic              found;
  logic [IDX_W-1:0]  match_idx;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;

  // Pending result.
  status_t           res_status;
  logic [KEY_W-1:0]  res_key;
  logic [DATA_W-1:0] res_value;

  logic              in_fire;
  logic              key_ok;
  logic [KEY_W-1:0]  key_m1;
  logic [SLOT_W-1:0] key_slot;
  logic              issue;
  logic              last;
  logic              hit;
  logic              empty;
  logic              del_hit;
  logic              out_free;
  entry_t            new_entry;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;
  logic              cl_we;
  logic [SLOT_W-1:0] cl_wa;
  logic [DATA_W-1:0] cl_wd;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign key_m1   = key_number - KEY_W'(1);
  assign key_slot = key_m1[SLOT_W-1:0];
  assign key_ok   = (key_number != '0) && (key_number <= KEY_W'(KEY_SLOTS));

  assign issue   = (cnt < CNT_W'(VALUE_ENTRIES));
  assign last    = rd_vld && (rd_idx == IDX_W'(VALUE_ENTRIES - 1));
  assign hit     = rd_vld && (rd_data.tid == tid_r) && (rd_data.key == key_r);
  assign empty   = rd_vld && (rd_data.tid == '0);
  assign del_hit = rd_vld && (rd_data.key == key_r);

  assign new_entry = '{tid: tid_r, key: key_r, data: val_r};

  // Memory write port: clearing sweep, delete scrub, set write-back.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt[IDX_W-1:0];
    mem_wd = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        if (op_r == OP_DELETE && del_hit) begin
          mem_we = 1'b1;
          mem_wa = rd_idx;
        end
      end
      S_FINISH: begin
        if (found) begin
          mem_we = 1'b1;
          mem_wa = match_idx;
          mem_wd = (val_r == '0) ? '0 : new_entry;
        end else if (val_r != '0 && empty_found) begin
          mem_we = 1'b1;
          mem_wa = empty_idx;
          mem_wd = new_entry;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Destructor handle port: claim on create, zero on delete.
  always_comb begin
    cl_we = 1'b0;
    cl_wa = slot_cnt;
    cl_wd = cleanup_handle;
    if (state == S_SLOT && !slot_active[slot_cnt]) begin
      cl_we = 1'b1;
      cl_wd = val_r;
    end else if (in_fire && opcode == OP_DELETE && key_ok) begin
      cl_we = 1'b1;
      cl_wa = key_slot;
      cl_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    rd_data <= entry_mem[cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cl_we) begin
      slot_cleanup[cl_wa] <= cl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      slot_active <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Load the output beat when a result is ready and the register frees;
      // drop it once taken otherwise.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(VALUE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            op_r        <= opcode_t'(opcode);
            key_r       <= key_number;
            tid_r       <= thread_id;
            // Create reuses the value register for the destructor handle.
            val_r       <= (opcode == OP_CREATE) ? cleanup_handle : item_value;
            cnt         <= '0;
            slot_cnt    <= '0;
            rd_vld      <= 1'b0;
            found       <= 1'b0;
            empty_found <= 1'b0;
            res_key     <= '0;
            res_value   <= '0;
            case (opcode_t'(opcode))
              OP_CREATE: begin
                res_status <= ST_OK;
                state      <= S_SLOT;
              end
              OP_DELETE: begin
                if (key_ok) begin
                  slot_active[key_slot] <= 1'b0;
                  res_status            <= ST_OK;
                  state                 <= S_SCAN;
                end else begin
                  res_status <= ST_ERR;
                  state      <= S_DONE;
                end
              end
              default: begin
                if (!key_ok || !slot_active[key_slot] || thread_id == '0) begin
                  res_status <= ST_ERR;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
            endcase
          end
        end

        S_SLOT: begin
          if (!slot_active[slot_cnt]) begin
            slot_active[slot_cnt] <= 1'b1;
            res_key               <= KEY_W'(slot_cnt) + KEY_W'(1);
            state                 <= S_DONE;
          end else if (slot_cnt == SLOT_W'(KEY_SLOTS - 1)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            slot_cnt <= slot_cnt + SLOT_W'(1);
          end
        end

        S_SCAN: begin
          // Issue the next read while the previous entry is evaluated.
          if (issue) begin
            cnt    <= cnt + CNT_W'(1);
            rd_idx <= cnt[IDX_W-1:0];
          end
          rd_vld <= issue;
          if (hit && !found) begin
            found     <= 1'b1;
            match_idx <= rd_idx;
            if (op_r == OP_GET) begin
              res_value <= rd_data.data;
            end
          end
          if (empty && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= rd_idx;
          end
          if (last) begin
            state <= (op_r == OP_SET) ? S_FINISH : S_DONE;
          end
        end

        S_FINISH: begin
          if (!found && val_r != '0 && !empty_found) begin
            res_status <= ST_FULL;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // Hold the result until the output register frees.
          if (out_free) begin
            status     <= res_status;
            new_key    <= res_key;
            read_value <= res_value;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/tb_thread_keyed_storage_table.sv @@
`default_nettype none

module tb_thread_keyed_storage_table;
  timeunit 1ns;
  timeprecision 1ps;
  import tkst_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int CYCLE_LIMIT = 2_000_000;
  // An operation walks every value entry, so allow a couple of full walks at the end.
  localparam int TAIL_CYCLES = 150;
  localparam int MAX_SHOWN   = 10;
  localparam int TID_POOL_N  = 6;
  localparam int BURST_SETS  = 70;

  // One operation beat as the sender presents it; hold asks the sender to drain first.
  typedef struct packed {
    logic              hold;
    opcode_t           op;
    logic [KEY_W-1:0]  key;
    logic [TID_W-1:0]  tid;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] handle;
  } table_op_t;

  typedef struct packed {
    status_t           st;
    logic [KEY_W-1:0]  nkey;
    logic [DATA_W-1:0] rval;
  } table_reply_t;

  logic              clk;
  logic              rst;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   opcode         = '0;
  logic [KEY_W-1:0]  key_number     = '0;
  logic [TID_W-1:0]  thread_id      = '0;
  logic [DATA_W-1:0] item_value     = '0;
  logic [DATA_W-1:0] cleanup_handle = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [ST_W-1:0]   status;
  logic [KEY_W-1:0]  new_key;
  logic [DATA_W-1:0] read_value;

  thread_keyed_storage_table u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .key_number     (key_number),
    .thread_id      (thread_id),
    .item_value     (item_value),
    .cleanup_handle (cleanup_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .new_key        (new_key),
    .read_value     (read_value)
  );

  // Shadow copy of the key slots and the value table.
  logic              key_live [KEY_SLOTS_DEF];
  logic [DATA_W-1:0] key_dtor [KEY_SLOTS_DEF];
  logic [TID_W-1:0]  ent_tid  [VALUE_ENTRIES_DEF];
  logic [KEY_W-1:0]  ent_key  [VALUE_ENTRIES_DEF];
  logic [DATA_W-1:0] ent_data [VALUE_ENTRIES_DEF];

  table_op_t    op_q[$];     // operations waiting to be driven
  table_reply_t reply_q[$];  // replies owed by the block, oldest first
  table_op_t    drv_op;

  logic [TID_W-1:0] tid_pool [TID_POOL_N];

  int planned_n  = 0;
  int taken_n    = 0;
  int replies_n  = 0;
  int mismatch_n = 0;
  int cycle_n    = 0;
  int full_n     = 0;
  int err_n      = 0;
  int hit_n      = 0;
  int op_seen [4];
  bit beat_taken = 1'b0;
  bit calm_in    = 1'b0;
  bit calm_out   = 1'b0;
  bit hold_next  = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset high at the start, then release it on a falling edge.
  initial begin
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
  end

  // Zero in a calm stretch; otherwise mostly zero, often short, now and then a long pause.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void drop_entry(input int idx);
    ent_tid[idx]  = '0;
    ent_key[idx]  = '0;
    ent_data[idx] = '0;
  endfunction

  // Apply one accepted operation to the shadow table and return the reply it owes.
  function automatic table_reply_t table_apply(input table_op_t b);
    table_reply_t r;
    int hit;
    int empty;
    bit key_ok;
    r.st   = ST_OK;
    r.nkey = '0;
    r.rval = '0;
    hit    = -1;
    empty  = -1;
    key_ok = (b.key != 0) && (b.key <= KEY_SLOTS_DEF);
    case (b.op)
      OP_CREATE: begin
        // Claim the lowest free slot; no free slot leaves everything as it was.
        r.st = ST_FULL;
        for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
          if (r.st == ST_FULL && !key_live[i]) begin
            key_live[i] = 1'b1;
            key_dtor[i] = b.handle;
            r.nkey      = KEY_W'(i + 1);
            r.st        = ST_OK;
          end
        end
      end
      OP_DELETE: begin
        // A free slot in range is cleared all the same and still answers OK.
        if (!key_ok) begin
          r.st = ST_ERR;
        end else begin
          key_live[b.key - 1] = 1'b0;
          key_dtor[b.key - 1] = '0;
          for (int i = 0; i < VALUE_ENTRIES_DEF; i++)
            if (ent_key[i] == b.key) drop_entry(i);
        end
      end
      default: begin
        // Thread zero would alias an empty entry, so reject it with bad keys.
        if (!key_ok || !key_live[b.key - 1] || b.tid == 0) begin
          r.st = ST_ERR;
        end else begin
          for (int i = 0; i < VALUE_ENTRIES_DEF; i++)
            if (hit < 0 && ent_tid[i] == b.tid && ent_key[i] == b.key) hit = i;
          if (b.op == OP_GET) begin
            if (hit >= 0) r.rval = ent_data[hit];
          end else if (hit >= 0) begin
            if (b.val != 0) ent_data[hit] = b.val;
            else drop_entry(hit);
          end else if (b.val != 0) begin
            for (int i = 0; i < VALUE_ENTRIES_DEF; i++)
              if (empty < 0 && ent_tid[i] == 0) empty = i;
            if (empty < 0) begin
              r.st = ST_FULL;
            end else begin
              ent_tid[empty]  = b.tid;
              ent_key[empty]  = b.key;
              ent_data[empty] = b.val;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_beat(input opcode_t op, input logic [KEY_W-1:0] key,
                          input logic [TID_W-1:0] tid, input logic [DATA_W-1:0] val,
                          input logic [DATA_W-1:0] handle);
    table_op_t b;
    b.hold    = hold_next;
    b.op      = op;
    b.key     = key;
    b.tid     = tid;
    b.val     = val;
    b.handle  = handle;
    hold_next = 1'b0;
    op_q.push_back(b);
    planned_n++;
  endtask

  // Keys mostly in range, with zero, above-range and full-range outliers.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return KEY_W'($urandom_range(1, KEY_SLOTS_DEF));
    if (r < 88) return '0;
    if (r < 94) return KEY_W'($urandom_range(KEY_SLOTS_DEF + 1, 255));
    return KEY_W'($urandom_range(0, 255));
  endfunction

  // A small pool of threads keeps matches common; fresh ids and zero fill the rest.
  function automatic logic [TID_W-1:0] pick_tid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return tid_pool[$urandom_range(0, TID_POOL_N - 1)];
    if (r < 95) return TID_W'($urandom);
    return '0;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 30) return DATA_W'($urandom_range(1, 15));
    if (r < 35) return '1;
    return rand64();
  endfunction

  task automatic add_random_beat();
    int r;
    opcode_t op;
    r = $urandom_range(0, 99);
    if (r < 12) op = OP_CREATE;
    else if (r < 22) op = OP_DELETE;
    else if (r < 57) op = OP_GET;
    else op = OP_SET;
    if ($urandom_range(0, 199) == 0) hold_next = 1'b1;
    add_beat(op, pick_key(), pick_tid(), pick_value(), rand64());
  endtask

  // Claim all slots, then pour in more fresh threads than the table holds, and read back.
  task automatic add_fill_burst();
    logic [TID_W-1:0] fresh [BURST_SETS];
    logic [KEY_W-1:0] fresh_key [BURST_SETS];
    int j;
    for (int i = 0; i < KEY_SLOTS_DEF; i++) add_beat(OP_CREATE, '0, '0, '0, rand64());
    for (int i = 0; i < BURST_SETS; i++) begin
      fresh[i]     = TID_W'($urandom_range(1, 32'h7FFF_FFFF));
      fresh_key[i] = KEY_W'($urandom_range(1, KEY_SLOTS_DEF));
      add_beat(OP_SET, fresh_key[i], fresh[i], rand64() | 64'd1, rand64());
    end
    for (int i = 0; i < 12; i++) begin
      j = $urandom_range(0, BURST_SETS - 1);
      add_beat(OP_GET, fresh_key[j], fresh[j], rand64(), rand64());
    end
  endtask

  // Stimulus: a directed opening, then random traffic with occasional fill bursts.
  initial begin
    int next_burst;
    for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
      key_live[i] = 1'b0;
      key_dtor[i] = '0;
    end
    for (int i = 0; i < VALUE_ENTRIES_DEF; i++) drop_entry(i);
    for (int i = 0; i < 4; i++) op_seen[i] = 0;
    tid_pool[0] = TID_W'(1);
    tid_pool[1] = '1;
    for (int i = 2; i < TID_POOL_N; i++) tid_pool[i] = TID_W'($urandom_range(1, 32'h7FFF_FFFF));

    // Rejected keys and a free slot before anything exists.
    add_beat(OP_GET,    8'd1,   31'd1, '0, '0);
    add_beat(OP_DELETE, 8'd0,   31'd1, '0, '0);
    add_beat(OP_DELETE, 8'd255, 31'd1, '0, '0);
    add_beat(OP_DELETE, 8'd9,   31'd1, '0, '0);
    add_beat(OP_DELETE, 8'd3,   31'd1, '0, '0);
    // Take every slot, then one more to hit the no-free-slot answer.
    add_beat(OP_CREATE, '0, '0, '0, '1);
    add_beat(OP_CREATE, '0, '0, '0, '0);
    for (int i = 0; i < KEY_SLOTS_DEF - 1; i++) add_beat(OP_CREATE, '0, '0, '0, rand64());
    // Store, read back, miss, thread zero, remove, no-op removal, bad key on set.
    add_beat(OP_SET,    8'd1, 31'd1, '1, '0);
    add_beat(OP_GET,    8'd1, 31'd1, '0, '1);
    add_beat(OP_GET,    8'd1, '1,    '1, '0);
    add_beat(OP_SET,    8'd8, '1,    64'd1, '0);
    add_beat(OP_SET,    8'd8, '0,    64'd5, '0);
    add_beat(OP_GET,    8'd2, '0,    '0, '0);
    add_beat(OP_SET,    8'd8, '1,    '0, '0);
    add_beat(OP_SET,    8'd5, 31'd7, '0, '0);
    add_beat(OP_SET,    8'd9, 31'd1, 64'd3, '0);
    // Delete a key holding an entry, then touch it while inactive.
    add_beat(OP_DELETE, 8'd1, 31'd1, '0, '0);
    add_beat(OP_GET,    8'd1, 31'd1, '0, '0);

    // Drain the directed part before the random traffic starts.
    hold_next  = 1'b1;
    next_burst = planned_n + 150;
    while (planned_n < ITEM_TARGET) begin
      if (planned_n >= next_burst || $urandom_range(0, 399) == 0) begin
        add_fill_burst();
        next_burst = planned_n + 500;
      end else begin
        add_random_beat();
      end
    end

    // Wait for every beat to go in and every reply to come back, then watch for strays.
    while (taken_n < planned_n || reply_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("ran %0d operations: %0d create, %0d delete, %0d get, %0d set",
             taken_n, op_seen[OP_CREATE], op_seen[OP_DELETE], op_seen[OP_GET], op_seen[OP_SET]);
    $display("checked %0d replies: %0d rejected, %0d out of room, %0d reads with data, %0d mismatches",
             replies_n, err_n, full_n, hit_n, mismatch_n);
    if (mismatch_n == 0) begin
      $display("thread_keyed_storage_table test passed");
    end else begin
      $display("thread_keyed_storage_table test failed");
    end
    $finish;
  end

  // Sender: advance on a taken beat, hold a stalled one, insert random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_q.size() != 0 && !(op_q[0].hold && reply_q.size() != 0)) begin
        drv_op = op_q.pop_front();
        opcode         <= drv_op.op;
        key_number     <= drv_op.key;
        thread_id      <= drv_op.tid;
        item_value     <= drv_op.val;
        cleanup_handle <= drv_op.handle;
        in_valid       <= 1'b1;
        // Flip between bursty and back-to-back stretches now and then.
        if ($urandom_range(0, 149) == 0) calm_in = !calm_in;
        gap_left = pick_gap(calm_in);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for random stretches, with calm periods of no stall at all.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_out = !calm_out;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_gap(calm_out);
    end
  end

  task automatic check_reply();
    table_reply_t want;
    if (reply_q.size() == 0) begin
      mismatch_n++;
      if (mismatch_n <= MAX_SHOWN)
        $display("stray reply at cycle %0d: status %0d new_key %0d read_value %h",
                 cycle_n, status, new_key, read_value);
    end else begin
      want = reply_q.pop_front();
      replies_n++;
      if (status !== want.st || new_key !== want.nkey || read_value !== want.rval) begin
        mismatch_n++;
        if (mismatch_n <= MAX_SHOWN) begin
          $display("reply %0d mismatch: status exp %0d got %0d, new_key exp %0d got %0d",
                   replies_n, want.st, status, want.nkey, new_key);
          $display("  read_value exp %h got %h", want.rval, read_value);
        end
      end
    end
  endtask

  // Monitor and predictor share the rising edge: check the reply first, then queue the new one.
  always @(posedge clk) begin
    table_reply_t owed;
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("no finish after %0d cycles, %0d replies still owed", cycle_n, reply_q.size());
      $display("thread_keyed_storage_table test failed");
      $finish;
    end
    beat_taken <= in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) check_reply();
    if (!rst && in_valid && !in_stall) begin
      owed = table_apply(drv_op);
      reply_q.push_back(owed);
      taken_n++;
      op_seen[drv_op.op]++;
      if (owed.st == ST_ERR) err_n++;
      if (owed.st == ST_FULL) full_n++;
      if (owed.rval != 0) hit_n++;
    end
  end

endmodule

`default_nettype wire
